/* design/bpa_pkg.sv */
// Shared types and constants for the buddy page allocator.
`default_nettype none

package bpa_pkg;

    localparam int PAGE_W     = 12;
    localparam int TOTAL_W    = 13;
    localparam int BASE_W     = 20;
    localparam int PIU_W      = 13;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_DONE     = 2'd0;
    localparam status_t STATUS_NO_BLOCK = 2'd1;
    localparam status_t STATUS_RANGE    = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 1'b1;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_AL_START,
        ST_AL_SCAN,
        ST_LS_CHECK,
        ST_LS_STEP,
        ST_LS_MARK,
        ST_LS_NEXT,
        ST_LS_LINK,
        ST_AL_DEL,
        ST_AL_DEL_INC,
        ST_AL_SPLIT,
        ST_AL_TAIL,
        ST_FR_P1,
        ST_FR_P2,
        ST_FB_START,
        ST_FB_BUD,
        ST_FB_MARK,
        ST_FB_MERGE,
        ST_FB_ADD,
        ST_D_READ,
        ST_D_MARK,
        ST_D_LINK,
        ST_A_LINK,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

/* design/bpa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* design/buddy_page_allocator.sv */
// Buddy page allocator top level: sequencer, free list registers and page memories.
//
// Requests enter on the s_ channel (mode, page_index, page_total) and one result
// item (status, first_page) leaves on the m_ channel for every request. An
// allocate rounds page_total up to an order, takes the head of the first
// non-empty list at or above it, splits it and frees the unused tail pages;
// above the top order it searches the top list for a run of free top blocks.
// A free releases the run in aligned chunks, merging each chunk with its buddy
// while the buddy is free. One request is worked at a time; s_ready is high
// only while the sequencer is idle. The time a request takes is set by the
// number of list unlinks, links, buddy checks and memory reads it performs;
// each list operation works on the page memories. The result sits in an
// output register, so the next request is accepted while an earlier result
// still waits for m_ready; a stalled receiver holds the sequencer only when
// a second result is ready to be written. After reset the page order marks
// are cleared one page per cycle; no request is accepted meanwhile, while
// configuration writes are always accepted. The free lists start empty and
// software seeds them by freeing the whole segment.
`default_nettype none

module buddy_page_allocator #(
    parameter int PAGE_COUNT   = 4096,
    parameter int ORDER_LEVELS = 9
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_mode,
    input  wire logic [bpa_pkg::PAGE_W-1:0]       s_page_index,
    input  wire logic [bpa_pkg::TOTAL_W-1:0]      s_page_total,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [bpa_pkg::STATUS_W-1:0]     m_status,
    output logic      [bpa_pkg::PAGE_W-1:0]       m_first_page,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bpa_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import bpa_pkg::*;

    localparam int PW    = $clog2(PAGE_COUNT);
    localparam int CW    = PW + 1;
    localparam int OW    = $clog2(ORDER_LEVELS);
    localparam int OXW   = $clog2(ORDER_LEVELS + 1);
    localparam int TOP   = ORDER_LEVELS - 1;
    localparam int FW    = BASE_W + CW + 2;
    localparam int ORD_W = $clog2(TOTAL_W + 1);
    localparam int KW    = ((OXW > ORD_W) ? OXW : ORD_W) + 1;

    localparam logic [OXW-1:0] NOT_FREE = OXW'(ORDER_LEVELS);
    localparam logic [OXW-1:0] TOP_O    = OXW'(TOP);
    localparam logic [FW-1:0]  TOP_SZ   = FW'(1) << TOP;

    function automatic logic [KW-1:0] ceil_log2(input logic [TOTAL_W-1:0] v);
        logic [TOTAL_W-1:0] m;
        logic [KW-1:0]      r;
        m = v - TOTAL_W'(1);
        r = '0;
        for (int i = 0; i < TOTAL_W; i++) begin
            if (m[i]) begin
                r = KW'(i + 1);
            end
        end
        return r;
    endfunction

    function automatic logic [OXW-1:0] frame_ord(input logic [FW-1:0] f);
        logic [OXW-1:0] r;
        r = TOP_O;
        for (int i = TOP - 1; i >= 0; i--) begin
            if (f[i]) begin
                r = OXW'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [OXW-1:0] msb_ord(input logic [CW-1:0] v);
        logic [OXW-1:0] r;
        r = '0;
        for (int i = 0; i < CW; i++) begin
            if (v[i]) begin
                r = OXW'(i);
            end
        end
        return r;
    endfunction

    state_t state_reg, state_next;
    state_t del_ret_reg, del_ret_next;
    state_t add_ret_reg, add_ret_next;
    state_t fb_ret_reg, fb_ret_next;

    logic [PW-1:0]      clr_reg, clr_next;
    logic [BASE_W-1:0]  base_reg, base_next;
    logic [PIU_W-1:0]   piu_reg, piu_next;
    logic [TOTAL_W-1:0] n_reg, n_next;
    logic [KW-1:0]      order_reg, order_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [OXW-1:0]     no_reg, no_next;
    logic [CW-1:0]      pg_reg, pg_next;
    logic [CW-1:0]      t_reg, t_next;
    logic [CW-1:0]      lsk_reg, lsk_next;
    logic [PW-1:0]      cur_reg, cur_next;
    logic [FW-1:0]      ps_reg, ps_next;
    logic [FW-1:0]      pe_reg, pe_next;
    logic [CW-1:0]      fr_pg_reg, fr_pg_next;
    logic [CW-1:0]      fr_n_reg, fr_n_next;
    logic [PW-1:0]      fb_pg_reg, fb_pg_next;
    logic [OXW-1:0]     fb_o_reg, fb_o_next;
    logic [FW-1:0]      pa_reg, pa_next;
    logic [PW-1:0]      bud_reg, bud_next;
    logic [PW-1:0]      add_pg_reg, add_pg_next;
    logic [OW-1:0]      add_o_reg, add_o_next;
    logic [PW-1:0]      del_pg_reg, del_pg_next;
    logic [OW-1:0]      del_o_reg, del_o_next;
    status_t            res_status_reg, res_status_next;
    logic [PW-1:0]      res_first_reg, res_first_next;
    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic [PW-1:0]      m_first_reg, m_first_next;

    logic [PW-1:0] head_reg [ORDER_LEVELS];
    logic [PW-1:0] head_next [ORDER_LEVELS];
    logic [PW-1:0] tail_reg [ORDER_LEVELS];
    logic [PW-1:0] tail_next [ORDER_LEVELS];
    logic [CW-1:0] len_reg [ORDER_LEVELS];
    logic [CW-1:0] len_next [ORDER_LEVELS];

    logic [OW-1:0] lst_idx;
    logic [PW-1:0] head_sel;
    logic [PW-1:0] tail_sel;
    logic [CW-1:0] len_sel;

    logic           mark_we;
    logic [PW-1:0]  mark_waddr;
    logic [OXW-1:0] mark_wdata;
    logic [PW-1:0]  mark_raddr;
    logic [OXW-1:0] mark_rdata;
    logic           next_we;
    logic [PW-1:0]  next_waddr;
    logic [PW-1:0]  next_wdata;
    logic [PW-1:0]  next_raddr;
    logic [PW-1:0]  next_rdata;
    logic           prev_we;
    logic [PW-1:0]  prev_waddr;
    logic [PW-1:0]  prev_wdata;
    logic [PW-1:0]  prev_raddr;
    logic [PW-1:0]  prev_rdata;

    logic [FW-1:0] base_w;
    logic [FW-1:0] size_w;
    logic [FW-1:0] seg_end;

    bpa_ram #(.WIDTH(OXW), .DEPTH(PAGE_COUNT)) u_mark_ram (
        .clk   (aclk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    bpa_ram #(.WIDTH(PW), .DEPTH(PAGE_COUNT)) u_next_ram (
        .clk   (aclk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (next_raddr),
        .rdata (next_rdata)
    );

    bpa_ram #(.WIDTH(PW), .DEPTH(PAGE_COUNT)) u_prev_ram (
        .clk   (aclk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (prev_raddr),
        .rdata (prev_rdata)
    );

    assign s_ready      = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_first_page = PAGE_W'(m_first_reg);

    assign base_w  = FW'(base_reg);
    assign size_w  = (FW'(piu_reg) > FW'(PAGE_COUNT)) ? FW'(PAGE_COUNT) : FW'(piu_reg);
    assign seg_end = base_w + size_w;

    always_comb begin
        case (state_reg)
            ST_AL_SCAN:  lst_idx = no_reg[OW-1:0];
            ST_AL_START: lst_idx = OW'(TOP);
            ST_LS_CHECK: lst_idx = OW'(TOP);
            ST_A_LINK:   lst_idx = add_o_reg;
            default:     lst_idx = del_o_reg;
        endcase
    end

    assign head_sel = head_reg[lst_idx];
    assign tail_sel = tail_reg[lst_idx];
    assign len_sel  = len_reg[lst_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            base_reg    <= '0;
            piu_reg     <= PIU_W'(4096);
            m_valid_reg <= 1'b0;
            for (int i = 0; i < ORDER_LEVELS; i++) begin
                len_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            base_reg    <= base_next;
            piu_reg     <= piu_next;
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < ORDER_LEVELS; i++) begin
                len_reg[i] <= len_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        del_ret_reg    <= del_ret_next;
        add_ret_reg    <= add_ret_next;
        fb_ret_reg     <= fb_ret_next;
        n_reg          <= n_next;
        order_reg      <= order_next;
        k_reg          <= k_next;
        no_reg         <= no_next;
        pg_reg         <= pg_next;
        t_reg          <= t_next;
        lsk_reg        <= lsk_next;
        cur_reg        <= cur_next;
        ps_reg         <= ps_next;
        pe_reg         <= pe_next;
        fr_pg_reg      <= fr_pg_next;
        fr_n_reg       <= fr_n_next;
        fb_pg_reg      <= fb_pg_next;
        fb_o_reg       <= fb_o_next;
        pa_reg         <= pa_next;
        bud_reg        <= bud_next;
        add_pg_reg     <= add_pg_next;
        add_o_reg      <= add_o_next;
        del_pg_reg     <= del_pg_next;
        del_o_reg      <= del_o_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        m_status_reg   <= m_status_next;
        m_first_reg    <= m_first_next;
        for (int i = 0; i < ORDER_LEVELS; i++) begin
            head_reg[i] <= head_next[i];
            tail_reg[i] <= tail_next[i];
        end
    end

    always_comb begin
        logic [FW-1:0]  ps;
        logic [FW-1:0]  pe;
        logic [FW-1:0]  psn;
        logic [FW-1:0]  pax;
        logic [FW-1:0]  pam;
        logic [FW-1:0]  step;
        logic [FW-1:0]  endv;
        logic [FW-1:0]  c;
        logic [OXW-1:0] o;
        logic [OXW-1:0] on;
        logic [KW-1:0]  kn;
        logic [KW-1:0]  lo;
        logic [CW-1:0]  apg;

        ps   = '0;
        pe   = '0;
        psn  = '0;
        pax  = '0;
        pam  = '0;
        step = '0;
        endv = '0;
        c    = '0;
        o    = '0;
        on   = '0;
        kn   = '0;
        lo   = '0;
        apg  = '0;

        state_next      = state_reg;
        del_ret_next    = del_ret_reg;
        add_ret_next    = add_ret_reg;
        fb_ret_next     = fb_ret_reg;
        clr_next        = clr_reg;
        base_next       = base_reg;
        piu_next        = piu_reg;
        n_next          = n_reg;
        order_next      = order_reg;
        k_next          = k_reg;
        no_next         = no_reg;
        pg_next         = pg_reg;
        t_next          = t_reg;
        lsk_next        = lsk_reg;
        cur_next        = cur_reg;
        ps_next         = ps_reg;
        pe_next         = pe_reg;
        fr_pg_next      = fr_pg_reg;
        fr_n_next       = fr_n_reg;
        fb_pg_next      = fb_pg_reg;
        fb_o_next       = fb_o_reg;
        pa_next         = pa_reg;
        bud_next        = bud_reg;
        add_pg_next     = add_pg_reg;
        add_o_next      = add_o_reg;
        del_pg_next     = del_pg_reg;
        del_o_next      = del_o_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_first_next    = m_first_reg;
        for (int i = 0; i < ORDER_LEVELS; i++) begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
            len_next[i]  = len_reg[i];
        end

        mark_we    = 1'b0;
        mark_waddr = del_pg_reg;
        mark_wdata = NOT_FREE;
        mark_raddr = del_pg_reg;
        next_we    = 1'b0;
        next_waddr = prev_rdata;
        next_wdata = next_rdata;
        next_raddr = del_pg_reg;
        prev_we    = 1'b0;
        prev_waddr = next_rdata;
        prev_wdata = prev_rdata;
        prev_raddr = del_pg_reg;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_BASE_FRAME:   base_next = cfg_data[BASE_W-1:0];
                CFG_PAGES_IN_USE: piu_next  = cfg_data[PIU_W-1:0];
                default:          base_next = base_reg;
            endcase
        end

        case (state_reg)
            ST_CLEAR: begin
                mark_we    = 1'b1;
                mark_waddr = clr_reg;
                mark_wdata = NOT_FREE;
                clr_next   = clr_reg + PW'(1);
                if (clr_reg == PW'(PAGE_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    n_next     = s_page_total;
                    order_next = ceil_log2(s_page_total);
                    if (s_mode == MODE_ALLOC) begin
                        if (s_page_total == '0 || FW'(s_page_total) > size_w) begin
                            res_status_next = STATUS_RANGE;
                            res_first_next  = '0;
                            state_next      = ST_FINISH;
                        end else begin
                            state_next = ST_AL_START;
                        end
                    end else begin
                        if (FW'(s_page_index) + FW'(s_page_total) > size_w) begin
                            res_status_next = STATUS_RANGE;
                            res_first_next  = '0;
                            state_next      = ST_FINISH;
                        end else begin
                            fr_pg_next      = CW'(s_page_index);
                            fr_n_next       = CW'(s_page_total);
                            res_status_next = STATUS_DONE;
                            res_first_next  = '0;
                            state_next      = ST_FR_P1;
                        end
                    end
                end
            end
            ST_AL_START: begin
                if (order_reg < KW'(ORDER_LEVELS)) begin
                    no_next    = OXW'(order_reg);
                    state_next = ST_AL_SCAN;
                end else begin
                    no_next    = TOP_O;
                    cur_next   = head_sel;
                    lsk_next   = '0;
                    state_next = ST_LS_CHECK;
                end
            end
            ST_AL_SCAN: begin
                if (no_reg == OXW'(ORDER_LEVELS)) begin
                    res_status_next = STATUS_NO_BLOCK;
                    res_first_next  = '0;
                    state_next      = ST_FINISH;
                end else if (len_sel != '0) begin
                    pg_next    = CW'(head_sel);
                    t_next     = CW'(head_sel);
                    k_next     = KW'(no_reg);
                    state_next = ST_AL_DEL;
                end else begin
                    no_next = OXW'(no_reg + OXW'(1));
                end
            end
            ST_LS_CHECK: begin
                if (lsk_reg >= len_sel) begin
                    res_status_next = STATUS_NO_BLOCK;
                    res_first_next  = '0;
                    state_next      = ST_FINISH;
                end else begin
                    ps = base_w + FW'(cur_reg);
                    pe = ps + FW'(n_reg);
                    if (pe <= seg_end) begin
                        ps_next    = ps;
                        pe_next    = pe;
                        state_next = ST_LS_STEP;
                    end else begin
                        state_next = ST_LS_NEXT;
                    end
                end
            end
            ST_LS_STEP: begin
                psn     = ps_reg + TOP_SZ;
                ps_next = psn;
                if (psn >= pe_reg) begin
                    pg_next    = CW'(cur_reg);
                    t_next     = CW'(cur_reg);
                    k_next     = KW'(no_reg);
                    state_next = ST_AL_DEL;
                end else if (psn < base_w || psn >= seg_end) begin
                    state_next = ST_LS_NEXT;
                end else begin
                    mark_raddr = PW'(psn - base_w);
                    state_next = ST_LS_MARK;
                end
            end
            ST_LS_MARK: begin
                if (mark_rdata == TOP_O) begin
                    state_next = ST_LS_STEP;
                end else begin
                    state_next = ST_LS_NEXT;
                end
            end
            ST_LS_NEXT: begin
                next_raddr = cur_reg;
                state_next = ST_LS_LINK;
            end
            ST_LS_LINK: begin
                cur_next   = next_rdata;
                lsk_next   = lsk_reg + CW'(1);
                state_next = ST_LS_CHECK;
            end
            ST_AL_DEL: begin
                if (FW'(t_reg) < FW'(pg_reg) + FW'(n_reg)) begin
                    del_pg_next  = PW'(t_reg);
                    del_ret_next = ST_AL_DEL_INC;
                    state_next   = ST_D_READ;
                end else begin
                    state_next = ST_AL_SPLIT;
                end
            end
            ST_AL_DEL_INC: begin
                t_next     = t_reg + (CW'(1) << no_reg);
                state_next = ST_AL_DEL;
            end
            ST_AL_SPLIT: begin
                if (k_reg > order_reg) begin
                    kn           = k_reg - KW'(1);
                    apg          = pg_reg + (CW'(1) << kn);
                    k_next       = kn;
                    add_pg_next  = PW'(apg);
                    add_o_next   = OW'(kn);
                    add_ret_next = ST_AL_SPLIT;
                    del_pg_next  = PW'(apg);
                    del_ret_next = ST_A_LINK;
                    state_next   = ST_D_READ;
                end else begin
                    state_next = ST_AL_TAIL;
                end
            end
            ST_AL_TAIL: begin
                lo   = (order_reg < KW'(no_reg)) ? order_reg : KW'(no_reg);
                step = FW'(1) << lo;
                endv = (FW'(n_reg) + step - FW'(1)) & ~(step - FW'(1));
                res_status_next = STATUS_DONE;
                res_first_next  = PW'(pg_reg);
                if (endv > FW'(n_reg)) begin
                    fr_pg_next = CW'(FW'(pg_reg) + FW'(n_reg));
                    fr_n_next  = CW'(endv - FW'(n_reg));
                    state_next = ST_FR_P1;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FR_P1: begin
                o = frame_ord(base_w + FW'(fr_pg_reg));
                c = FW'(1) << o;
                if (c > FW'(fr_n_reg)) begin
                    state_next = ST_FR_P2;
                end else begin
                    fb_pg_next  = PW'(fr_pg_reg);
                    fb_o_next   = o;
                    fr_n_next   = fr_n_reg - CW'(c);
                    fr_pg_next  = fr_pg_reg + CW'(c);
                    fb_ret_next = ST_FR_P1;
                    state_next  = ST_FB_START;
                end
            end
            ST_FR_P2: begin
                if (fr_n_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    o           = msb_ord(fr_n_reg);
                    c           = FW'(1) << o;
                    fb_pg_next  = PW'(fr_pg_reg);
                    fb_o_next   = o;
                    fr_n_next   = fr_n_reg - CW'(c);
                    fr_pg_next  = fr_pg_reg + CW'(c);
                    fb_ret_next = ST_FR_P2;
                    state_next  = ST_FB_START;
                end
            end
            ST_FB_START: begin
                if (fb_o_reg < TOP_O) begin
                    pa_next    = base_w + FW'(fb_pg_reg);
                    state_next = ST_FB_BUD;
                end else begin
                    state_next = ST_FB_ADD;
                end
            end
            ST_FB_BUD: begin
                pax = pa_reg ^ (FW'(1) << fb_o_reg);
                if (pax >= base_w && (pax - base_w) < size_w) begin
                    pa_next    = pax;
                    bud_next   = PW'(pax - base_w);
                    mark_raddr = PW'(pax - base_w);
                    state_next = ST_FB_MARK;
                end else begin
                    state_next = ST_FB_ADD;
                end
            end
            ST_FB_MARK: begin
                if (mark_rdata == fb_o_reg) begin
                    del_pg_next  = bud_reg;
                    del_ret_next = ST_FB_MERGE;
                    state_next   = ST_D_READ;
                end else begin
                    state_next = ST_FB_ADD;
                end
            end
            ST_FB_MERGE: begin
                on         = fb_o_reg + OXW'(1);
                pam        = pa_reg & ~((FW'(1) << on) - FW'(1));
                pa_next    = pam;
                fb_pg_next = PW'(pam - base_w);
                fb_o_next  = on;
                if (on < TOP_O) begin
                    state_next = ST_FB_BUD;
                end else begin
                    state_next = ST_FB_ADD;
                end
            end
            ST_FB_ADD: begin
                add_pg_next  = fb_pg_reg;
                add_o_next   = OW'(fb_o_reg);
                add_ret_next = fb_ret_reg;
                del_pg_next  = fb_pg_reg;
                del_ret_next = ST_A_LINK;
                state_next   = ST_D_READ;
            end
            ST_D_READ: begin
                mark_raddr = del_pg_reg;
                state_next = ST_D_MARK;
            end
            ST_D_MARK: begin
                if (mark_rdata >= NOT_FREE) begin
                    state_next = del_ret_reg;
                end else begin
                    del_o_next = OW'(mark_rdata);
                    next_raddr = del_pg_reg;
                    prev_raddr = del_pg_reg;
                    state_next = ST_D_LINK;
                end
            end
            ST_D_LINK: begin
                if (head_sel == del_pg_reg) begin
                    head_next[del_o_reg] = next_rdata;
                end else begin
                    next_we    = 1'b1;
                    next_waddr = prev_rdata;
                    next_wdata = next_rdata;
                end
                if (tail_sel == del_pg_reg) begin
                    tail_next[del_o_reg] = prev_rdata;
                end else begin
                    prev_we    = 1'b1;
                    prev_waddr = next_rdata;
                    prev_wdata = prev_rdata;
                end
                len_next[del_o_reg] = len_sel - CW'(1);
                mark_we    = 1'b1;
                mark_waddr = del_pg_reg;
                mark_wdata = NOT_FREE;
                state_next = del_ret_reg;
            end
            ST_A_LINK: begin
                mark_we    = 1'b1;
                mark_waddr = add_pg_reg;
                mark_wdata = OXW'(add_o_reg);
                prev_we    = 1'b1;
                prev_waddr = add_pg_reg;
                prev_wdata = tail_sel;
                if (len_sel != '0) begin
                    next_we    = 1'b1;
                    next_waddr = tail_sel;
                    next_wdata = add_pg_reg;
                end else begin
                    head_next[add_o_reg] = add_pg_reg;
                end
                tail_next[add_o_reg] = add_pg_reg;
                len_next[add_o_reg]  = len_sel + CW'(1);
                state_next = add_ret_reg;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_first_next  = res_first_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("a second item was accepted while a request was in progress");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_DONE |-> m_first_page == '0)
        else $error("failed request reports a nonzero first page");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STATUS_DONE || m_status == STATUS_NO_BLOCK ||
                     m_status == STATUS_RANGE))
        else $error("result carries an unknown status code");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared outside the finish step");

    a_unlink_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_D_LINK |-> len_sel != '0)
        else $error("unlinking a page from an empty free list");

endmodule

`default_nettype wire
